FILE: hdl/wsfd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_pkg
// Types, codes and constants shared by the frame delimiter modules.
// ---------------------------------------------------------------------------
package wsfd_pkg;

	localparam int HOLD_DEPTH      = 10;
	localparam int HOLD_IDX_W      = 4;
	localparam int REM_W           = 33;
	localparam int CFG_DATA_W      = 32;
	localparam int CFG_ADDR_W      = 3;
	localparam int CMDQ_DEPTH_DEF  = 2;

	localparam logic [CFG_DATA_W-1:0] MAX_FRAME_RESET = 32'd65536;
	localparam logic [CFG_ADDR_W-3:0] REG_MAX_FRAME   = 1'b0;

	localparam logic       CMD_DATA   = 1'b0;
	localparam logic       CMD_EOF    = 1'b1;
	localparam logic [6:0] LEN16_CODE = 7'd126;
	localparam logic [6:0] LEN64_CODE = 7'd127;
	localparam logic [3:0] BASE_HDR   = 4'd2;
	localparam logic [3:0] EXT16_LEN  = 4'd2;
	localparam logic [3:0] EXT64_LEN  = 4'd8;
	localparam logic [3:0] MASK_LEN   = 4'd4;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_TOO_LARGE = 2'd1,
		KIND_EOF       = 2'd2
	} kind_t;

	typedef enum logic {
		PH_HUNT = 1'b0,
		PH_PASS = 1'b1
	} phase_t;

	typedef struct packed {
		logic       command;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		kind_t      result_kind;
		logic [7:0] frame_byte;
		logic       frame_end;
		logic       run_last;
	} result_t;

	typedef logic [HOLD_DEPTH-1:0][7:0] hdr_t;

	// one queue entry: a single result, or a release of held header bytes
	typedef struct packed {
		logic                  is_release;
		kind_t                 kind;
		logic [7:0]            data_byte;
		logic                  end_flag;
		logic [HOLD_IDX_W-1:0] cnt;
		hdr_t                  hdr;
	} cmd_t;

endpackage

FILE: hdl/websocket_frame_delimiter.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// websocket_frame_delimiter
// Cuts a received byte stream into whole frames by their length prefix.
// ---------------------------------------------------------------------------
// path: an accepted item's first result passes the command queue, then the back part's output register
// throughput: one item per cycle; a header release is stepped out byte by byte in the back,
//   the front keeps taking items until the command queue (CMDQ_DEPTH entries) fills
// reset: asynchronous, clears phase, counts, halt and queue; limit returns to 65536;
//   held header bytes are undefined and need no clearing pass
module websocket_frame_delimiter #(
	parameter int CMDQ_DEPTH = wsfd_pkg::CMDQ_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  wsfd_pkg::item_t                 item,
	output logic                            empty,
	input  logic                            pop,
	output wsfd_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [wsfd_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [wsfd_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [wsfd_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import wsfd_pkg::*;

	logic [CFG_DATA_W-1:0] max_frame_q;
	logic                  reg_hit;
	logic                  cmd_push;
	logic                  cmd_full;
	cmd_t                  cmd;
	cmd_t                  head;
	logic                  head_empty;
	logic                  head_pop;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_MAX_FRAME);
	assign prdata  = reg_hit ? max_frame_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			max_frame_q <= pwdata;
		end
	end

	wsfd_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.item            (item),
		.max_frame_bytes (max_frame_q),
		.cmd_push        (cmd_push),
		.cmd_full        (cmd_full),
		.cmd             (cmd)
	);

	wsfd_cmdq #(
		.DEPTH (CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wdata  (cmd),
		.full   (cmd_full),
		.rd     (head_pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	wsfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

FILE: hdl/wsfd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_front
// Accepts items, gathers the header, works out the frame length and
// queues single results or header release bursts.
// ---------------------------------------------------------------------------
module wsfd_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  wsfd_pkg::item_t                 item,
	input  logic [wsfd_pkg::CFG_DATA_W-1:0] max_frame_bytes,
	output logic                            cmd_push,
	input  logic                            cmd_full,
	output wsfd_pkg::cmd_t                  cmd
);
	import wsfd_pkg::*;

	hdr_t                  hdr_q;
	logic [HOLD_IDX_W-1:0] held_q;
	logic [REM_W-1:0]      rem_q;
	phase_t                phase_q;
	logic                  halted_q;

	hdr_t                  hdr_n;
	logic [HOLD_IDX_W-1:0] idx;
	logic [HOLD_IDX_W-1:0] cnt;
	logic [HOLD_IDX_W-1:0] ext;
	logic [6:0]            len7;
	logic [31:0]           pay;
	logic                  sat;
	logic                  known;
	logic [REM_W-1:0]      total;
	logic [REM_W-1:0]      rem_dec;
	logic                  take;
	logic                  hdr_wr;

	logic [HOLD_IDX_W-1:0] held_d;
	logic [REM_W-1:0]      rem_d;
	phase_t                phase_d;
	logic                  halted_d;

	assign full = cmd_full;
	assign take = push && !cmd_full;

	// header as it stands with the new byte in place
	always_comb begin
		idx = (held_q >= HOLD_IDX_W'(HOLD_DEPTH)) ? '0 : held_q;
		cnt = idx + 1'b1;
		hdr_n = hdr_q;
		hdr_n[idx] = item.data_byte;
		len7 = hdr_n[1][6:0];
		if (len7 == LEN16_CODE) begin
			ext = EXT16_LEN;
			pay = {16'd0, hdr_n[2], hdr_n[3]};
		end else if (len7 == LEN64_CODE) begin
			ext = EXT64_LEN;
			pay = {hdr_n[6], hdr_n[7], hdr_n[8], hdr_n[9]};
		end else begin
			ext = '0;
			pay = {25'd0, len7};
		end
		sat = (len7 == LEN64_CODE) && (|{hdr_n[2], hdr_n[3], hdr_n[4], hdr_n[5]});
		known = (cnt >= BASE_HDR) && (cnt >= BASE_HDR + ext);
		total = REM_W'(BASE_HDR) + REM_W'(ext) + (hdr_n[1][7] ? REM_W'(MASK_LEN) : '0)
			+ REM_W'(pay);
		rem_dec = rem_q - 1'b1;
	end

	always_comb begin
		held_d   = held_q;
		rem_d    = rem_q;
		phase_d  = phase_q;
		halted_d = halted_q;
		hdr_wr   = 1'b0;
		cmd_push = 1'b0;
		cmd            = '0;
		cmd.is_release = 1'b0;
		cmd.kind       = KIND_BYTE;
		cmd.cnt        = cnt;
		cmd.hdr        = hdr_n;
		if (take && !halted_q) begin
			if (item.command == CMD_EOF) begin
				cmd_push = 1'b1;
				cmd.kind = KIND_EOF;
				held_d   = '0;
				rem_d    = '0;
				phase_d  = PH_HUNT;
			end else begin
				case (phase_q)
					PH_PASS: begin
						cmd_push      = 1'b1;
						cmd.data_byte = item.data_byte;
						cmd.end_flag  = (rem_dec == '0);
						rem_d         = rem_dec;
						if (rem_dec == '0) begin
							phase_d = PH_HUNT;
						end
					end
					default: begin
						hdr_wr = 1'b1;
						if ((known && (sat || total > {1'b0, max_frame_bytes}))
							|| (!known && 32'(cnt) >= max_frame_bytes)) begin
							cmd_push = 1'b1;
							cmd.kind = KIND_TOO_LARGE;
							halted_d = 1'b1;
							held_d   = '0;
							rem_d    = '0;
							phase_d  = PH_HUNT;
						end else if (!known) begin
							held_d = cnt;
						end else begin
							cmd_push       = 1'b1;
							cmd.is_release = 1'b1;
							held_d         = '0;
							if (total <= REM_W'(cnt)) begin
								cmd.end_flag = 1'b1;
								rem_d        = '0;
								phase_d      = PH_HUNT;
							end else begin
								rem_d   = total - REM_W'(cnt);
								phase_d = PH_PASS;
							end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			held_q   <= '0;
			rem_q    <= '0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			held_q   <= held_d;
			rem_q    <= rem_d;
			halted_q <= halted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_wr) begin
			hdr_q[idx] <= item.data_byte;
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_pass_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PASS) |-> (rem_q != '0))
		else $error("passing frame bytes with nothing left");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !cmd_push)
		else $error("result queued while halted");

endmodule

FILE: hdl/wsfd_cmdq.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_cmdq
// Short queue of commands between the front and back parts.
// ---------------------------------------------------------------------------
module wsfd_cmdq #(
	parameter int DEPTH = wsfd_pkg::CMDQ_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  wsfd_pkg::cmd_t wdata,
	output logic           full,
	input  logic           rd,
	output wsfd_pkg::cmd_t rdata,
	output logic           empty
);
	import wsfd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr;
	logic          do_rd;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full))
		else $error("command queue written while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("command queue count out of range");

endmodule

FILE: hdl/wsfd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsfd_back
// Turns queued commands into results, stepping through header releases
// one byte a cycle while results are taken, into an output register.
// ---------------------------------------------------------------------------
module wsfd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  wsfd_pkg::cmd_t    head,
	input  logic              head_empty,
	output logic              head_pop,
	output logic              empty,
	input  logic              pop,
	output wsfd_pkg::result_t result
);
	import wsfd_pkg::*;

	logic [HOLD_IDX_W-1:0] idx_q;
	logic                  valid_q;
	result_t               out_q;

	logic                  load;
	logic                  last;
	result_t               next_res;

	assign empty  = !valid_q;
	assign result = out_q;
	assign load   = (!valid_q || pop) && !head_empty;
	assign last   = (idx_q == head.cnt - 1'b1);

	always_comb begin
		next_res = '0;
		if (head.is_release) begin
			next_res.result_kind = KIND_BYTE;
			next_res.frame_byte  = head.hdr[idx_q];
			next_res.frame_end   = last && head.end_flag;
			next_res.run_last    = last;
			head_pop             = load && last;
		end else begin
			next_res.result_kind = head.kind;
			next_res.frame_byte  = head.data_byte;
			next_res.frame_end   = head.end_flag;
			next_res.run_last    = 1'b1;
			head_pop             = load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= (head.is_release && !last) ? idx_q + 1'b1 : '0;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= next_res;
		end
	end

	a_end_only_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_q.frame_end) |-> (out_q.result_kind == KIND_BYTE && out_q.run_last))
		else $error("frame end flagged on a non-byte or mid-burst result");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !pop) |=> (valid_q && $stable(out_q)))
		else $error("waiting result changed before it was taken");

endmodule
